/* hw/rtl/keyed_entry_table_with_expiry_core_defines.svh */
// Assertion macros for the keyed entry table with expiry core.
// Used by the port checker; needs clock and reset in the enclosing scope.
`ifndef KEYED_ENTRY_TABLE_WITH_EXPIRY_CORE_DEFINES_SVH
`define KEYED_ENTRY_TABLE_WITH_EXPIRY_CORE_DEFINES_SVH

// cons holds in the same cycle as ante
`define KET_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ket port check failed in the same cycle");

// cons holds in the cycle after ante
`define KET_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ket port check failed in the next cycle");

`endif

/* hw/rtl/ket_pkg.sv */
// Shared types and constants of the keyed entry table with expiry core.
// No dependencies; imported by every module of the block.
package ket_pkg;

   localparam int TABLE_DEPTH_DEF = 32;

   localparam logic [31:0] LIFETIME_RESET = 32'd1000;
   localparam logic [31:0] MIN_LIFETIME   = 32'd1;

   localparam logic [1:0] REQ_ADD      = 2'd0;
   localparam logic [1:0] REQ_TICK     = 2'd1;
   localparam logic [1:0] REQ_CLEAR    = 2'd2;
   localparam logic [1:0] REQ_RESERVED = 2'd3;

   localparam logic [2:0] KIND_INSERTED = 3'd0;
   localparam logic [2:0] KIND_REPLACED = 3'd1;
   localparam logic [2:0] KIND_DROPPED  = 3'd2;
   localparam logic [2:0] KIND_EXPIRED  = 3'd3;
   localparam logic [2:0] KIND_DONE     = 3'd4;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] source_id;
      logic [31:0] entry_key;
      logic [31:0] now_ms;
   } ket_req_type;

   typedef struct packed {
      logic [2:0]  result_kind;
      logic [31:0] out_source_id;
      logic [31:0] out_key;
      logic        last;
   } ket_rsp_type;

   typedef struct packed {
      logic [31:0] owner;
      logic [31:0] key;
      logic [31:0] created;
   } ket_entry_type;

endpackage

/* hw/rtl/keyed_entry_table_with_expiry_core.sv */
// Top level of the keyed entry table with expiry: sequencer plus entry memory.
// Depends on ket_pkg, ket_ctrl and ket_mem.
//
// Request timing: an item is taken when start is high and busy is low. Add and
// tick walk the entry memory through its single read port, one slot per cycle.
// An add ends at the first valid slot whose key matches; an add that misses or
// is dropped ends after the last slot; a tick ends with a flush state after it.
// Clear and unknown request kinds leave busy low. Every result is shown on
// rsp_item for exactly one cycle with rsp_valid high and must be taken then;
// the last result of a request appears in the same cycle as busy falls (for clear,
// in the cycle after the request), and expired items of a tick arrive in slot
// order during the sweep. The lifetime may be written whenever no request is open.
module keyed_entry_table_with_expiry_core
   import ket_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  ket_req_type req_item,
   output logic        rsp_valid,
   output ket_rsp_type rsp_item,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   ket_entry_type    mem_wr_data;
   logic [IDX_W-1:0] mem_rd_addr;
   ket_entry_type    mem_rd_data;

   ket_ctrl #(
      .DEPTH (TABLE_DEPTH),
      .IDX_W (IDX_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   ket_mem #(
      .DEPTH (TABLE_DEPTH),
      .IDX_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

/* hw/rtl/ket_mem.sv */
// Entry memory: owner, key and creation time per slot.
// One write port, one read port with registered data; uses ket_pkg.
module ket_mem
   import ket_pkg::*;
#(
   parameter int DEPTH = TABLE_DEPTH_DEF,
   parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  ket_entry_type    wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output ket_entry_type    rd_data
);

   ket_entry_type mem [DEPTH];
   ket_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/ket_ctrl.sv */
// Request sequencer: sweeps the entry memory one slot per cycle for add and tick,
// holds valid bits, lifetime and the result register; uses ket_pkg.
module ket_ctrl
   import ket_pkg::*;
#(
   parameter int DEPTH = TABLE_DEPTH_DEF,
   parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ket_req_type      req_item,
   output logic             rsp_valid,
   output ket_rsp_type      rsp_item,
   input  logic             csr_we,
   input  logic [31:0]      csr_wdata,
   output logic             mem_wr_en,
   output logic [IDX_W-1:0] mem_wr_addr,
   output ket_entry_type    mem_wr_data,
   output logic [IDX_W-1:0] mem_rd_addr,
   input  ket_entry_type    mem_rd_data
);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FLUSH} state_type;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

   state_type        state_ff, state_in;
   ket_req_type      req_ff, req_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic             issue_done_ff, issue_done_in;
   logic             chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic [IDX_W-1:0] free_ff, free_in;
   logic             free_vld_ff, free_vld_in;
   ket_rsp_type      pend_ff, pend_in;
   logic             pend_vld_ff, pend_vld_in;
   logic [DEPTH-1:0] valid_ff, valid_in;
   logic [31:0]      lifetime_ff, lifetime_in;
   logic             rsp_valid_ff, rsp_valid_in;
   ket_rsp_type      rsp_ff, rsp_in;

   logic        cur_valid;
   logic        chk_last;
   logic        hit;
   logic [31:0] age;
   logic        expired;

   assign cur_valid = valid_ff[chk_idx_ff];
   assign chk_last  = (chk_idx_ff == LAST_IDX);
   assign hit       = cur_valid && (mem_rd_data.key == req_ff.entry_key);
   assign age       = req_ff.now_ms - mem_rd_data.created;
   assign expired   = cur_valid && !age[31] && (age >= lifetime_ff);

   assign mem_wr_data.owner   = req_ff.source_id;
   assign mem_wr_data.key     = req_ff.entry_key;
   assign mem_wr_data.created = req_ff.now_ms;
   assign mem_rd_addr         = addr_ff;

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      addr_in       = addr_ff;
      issue_done_in = issue_done_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      free_in       = free_ff;
      free_vld_in   = free_vld_ff;
      pend_in       = pend_ff;
      pend_vld_in   = pend_vld_ff;
      valid_in      = valid_ff;
      lifetime_in   = lifetime_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = chk_idx_ff;

      if (csr_we) begin
         lifetime_in = (csr_wdata < MIN_LIFETIME) ? MIN_LIFETIME : csr_wdata;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in        = req_item;
               addr_in       = '0;
               issue_done_in = 1'b0;
               free_vld_in   = 1'b0;
               pend_vld_in   = 1'b0;
               case (req_item.req_type)
                  REQ_ADD, REQ_TICK: begin
                     state_in = ST_SCAN;
                  end
                  REQ_CLEAR: begin
                     valid_in     = '0;
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{KIND_DONE, 32'd0, 32'd0, 1'b1};
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{KIND_DONE, 32'd0, 32'd0, 1'b1};
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // issue next read
            if (!issue_done_ff) begin
               chk_vld_in = 1'b1;
               chk_idx_in = addr_ff;
               addr_in    = IDX_W'(addr_ff + 1'b1);
               if (addr_ff == LAST_IDX) begin
                  issue_done_in = 1'b1;
               end
            end
            // check slot read last cycle
            if (chk_vld_ff) begin
               if (req_ff.req_type == REQ_ADD) begin
                  if (hit) begin
                     mem_wr_en    = 1'b1;
                     mem_wr_addr  = chk_idx_ff;
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{KIND_REPLACED, req_ff.source_id, req_ff.entry_key, 1'b1};
                     state_in     = ST_IDLE;
                  end else begin
                     if (!cur_valid && !free_vld_ff) begin
                        free_in     = chk_idx_ff;
                        free_vld_in = 1'b1;
                     end
                     if (chk_last) begin
                        rsp_valid_in = 1'b1;
                        state_in     = ST_IDLE;
                        if (free_vld_in) begin
                           mem_wr_en         = 1'b1;
                           mem_wr_addr       = free_in;
                           valid_in[free_in] = 1'b1;
                           rsp_in = '{KIND_INSERTED, req_ff.source_id, req_ff.entry_key, 1'b1};
                        end else begin
                           rsp_in = '{KIND_DROPPED, req_ff.source_id, req_ff.entry_key, 1'b1};
                        end
                     end
                  end
               end else begin
                  // tick: hold one expired item back so the final one can carry last
                  if (expired) begin
                     valid_in[chk_idx_ff] = 1'b0;
                     if (pend_vld_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = pend_ff;
                     end
                     pend_in     = '{KIND_EXPIRED, mem_rd_data.owner, mem_rd_data.key, 1'b0};
                     pend_vld_in = 1'b1;
                  end
                  if (chk_last) begin
                     state_in = ST_FLUSH;
                  end
               end
            end
         end
         ST_FLUSH: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            if (pend_vld_ff) begin
               rsp_in      = pend_ff;
               rsp_in.last = 1'b1;
            end else begin
               rsp_in = '{KIND_DONE, 32'd0, 32'd0, 1'b1};
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         addr_ff       <= '0;
         issue_done_ff <= 1'b0;
         chk_vld_ff    <= 1'b0;
         free_vld_ff   <= 1'b0;
         pend_vld_ff   <= 1'b0;
         valid_ff      <= '0;
         lifetime_ff   <= LIFETIME_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         issue_done_ff <= issue_done_in;
         chk_vld_ff    <= chk_vld_in;
         free_vld_ff   <= free_vld_in;
         pend_vld_ff   <= pend_vld_in;
         valid_ff      <= valid_in;
         lifetime_ff   <= lifetime_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      req_ff     <= req_in;
      chk_idx_ff <= chk_idx_in;
      free_ff    <= free_in;
      pend_ff    <= pend_in;
      rsp_ff     <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

/* hw/rtl/ket_checker.sv */
// Port checker for the keyed entry table with expiry core, bound to the top level.
// Depends on ket_pkg and keyed_entry_table_with_expiry_core_defines.svh.
`include "keyed_entry_table_with_expiry_core_defines.svh"

module ket_checker
   import ket_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input ket_req_type req_item,
   input logic        rsp_valid,
   input ket_rsp_type rsp_item,
   input logic        csr_we,
   input logic [31:0] csr_wdata
);

   logic take;
   logic add_req;
   logic short_req;
   logic done_rsp;
   logic done_zero;
   logic more_rsp;
   logic sweep_rsp;
   logic cfg_ok;

   assign take      = start && !busy;
   assign add_req   = take && (req_item.req_type == REQ_ADD);
   assign short_req = take && (req_item.req_type inside {REQ_CLEAR, REQ_RESERVED});
   assign done_rsp  = rsp_valid && (rsp_item.result_kind == KIND_DONE);
   assign done_zero = (rsp_item.out_source_id == 32'd0) && (rsp_item.out_key == 32'd0)
                      && rsp_item.last;
   assign more_rsp  = rsp_valid && !rsp_item.last;
   assign sweep_rsp = busy && (rsp_item.result_kind == KIND_EXPIRED);
   assign cfg_ok    = !busy && !$isunknown(csr_wdata);

   `KET_ASSERT_NEXT(a_add_sweeps, add_req, busy)
   `KET_ASSERT_NEXT(a_short_done, short_req, done_rsp && rsp_item.last)
   `KET_ASSERT_SAME(a_more_follows, more_rsp, sweep_rsp)
   `KET_ASSERT_SAME(a_done_empty, done_rsp, done_zero)
   `KET_ASSERT_SAME(a_cfg_idle, csr_we, cfg_ok)

endmodule

bind keyed_entry_table_with_expiry_core ket_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item),
   .csr_we    (csr_we),
   .csr_wdata (csr_wdata)
);
